// ===== rtl/svrp_pkg.sv =====
`timescale 1ns / 1ps

package svrp_pkg;

   // Default build of the voice.
   localparam int DEF_MAX_FRAMES      = 65536;
   localparam int DEF_SAMPLE_BITS     = 16;
   localparam int DEF_PHASE_FRAC_BITS = 16;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_STEP    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN          = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_IN_STEP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_OUT_STEP = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_COUNT   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_PLAY      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEREO        = 3'd6;

   // Stream payload widths.
   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   // Envelope unity level, Q1.15.
   localparam logic [15:0] LEVEL_UNITY = 16'h8000;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic mem_write;
      logic voice_start;
      logic voice_stop;
      logic tick_eval;
      logic interp_en;
      logic scale_en;
      logic out_load;
   } svrp_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic [1:0] op;
      logic       out_free;
   } svrp_status_type;

   // A fade step of zero behaves as one, anything above unity as unity.
   function automatic logic [15:0] clamp_step(input logic [15:0] step);
      logic [15:0] res;
      res = step;
      if (step == 16'd0) begin
         res = 16'd1;
      end else if (step > LEVEL_UNITY) begin
         res = LEVEL_UNITY;
      end
      return res;
   endfunction

endpackage

// ===== rtl/svrp_ctrl.sv =====
`timescale 1ns / 1ps

module svrp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  svrp_pkg::svrp_status_type   status,
   output svrp_pkg::svrp_cmd_type      cmd
);
   import svrp_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_INTERP = 3'd2;
   localparam logic [2:0] S_SCALE  = 3'd3;
   localparam logic [2:0] S_SUM    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // One item at a time: a new transaction is taken only from idle.
   assign req_tready = (state_ff == S_IDLE);

   // Sequencing of the datapath steps for each operation.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               OP_WRITE: begin
                  cmd.mem_write = 1'b1;
                  state_in      = S_IDLE;
               end
               OP_START: begin
                  cmd.voice_start = 1'b1;
                  state_in        = S_IDLE;
               end
               OP_STOP: begin
                  cmd.voice_stop = 1'b1;
                  state_in       = S_IDLE;
               end
               OP_TICK: begin
                  cmd.tick_eval = 1'b1;
                  state_in      = S_INTERP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INTERP: begin
            cmd.interp_en = 1'b1;
            state_in      = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            // Wait here while the previous result is still unclaimed.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/svrp_datapath.sv =====
`timescale 1ns / 1ps

module svrp_datapath #(
   parameter int MAX_FRAMES      = svrp_pkg::DEF_MAX_FRAMES,
   parameter int SAMPLE_BITS     = svrp_pkg::DEF_SAMPLE_BITS,
   parameter int PHASE_FRAC_BITS = svrp_pkg::DEF_PHASE_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  svrp_pkg::svrp_cmd_type             cmd,
   output svrp_pkg::svrp_status_type          status,
   input  logic [svrp_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic [svrp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               csr_valid,
   input  logic [svrp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [svrp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [svrp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import svrp_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FRAMES);
   localparam int IDX_W  = 32 - PHASE_FRAC_BITS;
   localparam int FC_W   = (ADDR_W + 1 > 17) ? ADDR_W + 1 : 17;
   localparam int CMP_W  = ((FC_W > IDX_W) ? FC_W : IDX_W) + 1;
   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int IPW    = DIFF_W + PHASE_FRAC_BITS + 1;
   localparam int SPW    = SAMPLE_BITS + 33;
   localparam int SH     = SAMPLE_BITS + 13;
   localparam int ACC_W  = SPW - SH;
   localparam int UP_SH  = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
   localparam int DN_SH  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
   localparam logic signed [SPW-1:0] BIAS = SPW'(1) <<< (SH - 1);

   // Configuration reset values.
   localparam logic [23:0] PHASE_STEP_RST    = 24'd65536;
   localparam logic [15:0] GAIN_RST          = 16'd8211;
   localparam logic [15:0] FADE_IN_STEP_RST  = 16'd34;
   localparam logic [15:0] FADE_OUT_STEP_RST = 16'd14;
   localparam logic [16:0] FRAME_COUNT_RST   = 17'd1;

   // Saturate the mix sum to a 16-bit sample.
   function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
      logic [15:0] res;
      res = v[15:0];
      if (v > ACC_W'(32767)) begin
         res = 16'h7FFF;
      end else if (v < -ACC_W'(32768)) begin
         res = 16'h8000;
      end
      return res;
   endfunction

   // Configuration registers.
   logic [23:0] phase_step_ff;
   logic [15:0] gain_ff;
   logic [15:0] fade_in_step_ff;
   logic [15:0] fade_out_step_ff;
   logic [16:0] frame_count_ff;
   logic [31:0] max_play_ff;
   logic        stereo_ff;

   // Captured request.
   logic [1:0]         op_ff;
   logic [15:0]        addr_ff;
   logic signed [15:0] wl_ff;
   logic signed [15:0] wr_ff;
   logic signed [15:0] mix_l_ff;
   logic signed [15:0] mix_r_ff;

   // Voice state.
   logic [31:0] phase_ff, phase_in;
   logic [15:0] fil_ff, fil_in;
   logic [15:0] fol_ff, fol_in;
   logic        fading_ff, fading_in;
   logic        playing_ff, playing_in;
   logic [31:0] elapsed_ff, elapsed_in;

   // Sample store, right channel in the upper half.
   logic [2*SAMPLE_BITS-1:0] sample_mem [MAX_FRAMES];
   logic [2*SAMPLE_BITS-1:0] rd0_ff;
   logic [2*SAMPLE_BITS-1:0] rd1_ff;

   // Pipeline registers.
   logic [PHASE_FRAC_BITS-1:0]   frac_ff;
   logic [15:0]                  env_ff;
   logic                         zero_ff;
   logic                         active_ff;
   logic                         fin_ff;
   logic signed [IPW-1:0]        iprod_l_ff;
   logic signed [IPW-1:0]        iprod_r_ff;
   logic [31:0]                  ge_ff;
   logic signed [SPW-1:0]        vprod_l_ff;
   logic signed [SPW-1:0]        vprod_r_ff;

   // Output register.
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   // Configuration writes; any index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= PHASE_STEP_RST;
         gain_ff          <= GAIN_RST;
         fade_in_step_ff  <= FADE_IN_STEP_RST;
         fade_out_step_ff <= FADE_OUT_STEP_RST;
         frame_count_ff   <= FRAME_COUNT_RST;
         max_play_ff      <= 32'd0;
         stereo_ff        <= 1'b1;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata[23:0];
            CSR_GAIN:          gain_ff          <= csr_wdata[15:0];
            CSR_FADE_IN_STEP:  fade_in_step_ff  <= csr_wdata[15:0];
            CSR_FADE_OUT_STEP: fade_out_step_ff <= csr_wdata[15:0];
            CSR_FRAME_COUNT:   frame_count_ff   <= csr_wdata[16:0];
            CSR_MAX_PLAY:      max_play_ff      <= csr_wdata;
            CSR_STEREO:        stereo_ff        <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Request capture on an accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser;
         addr_ff  <= req_tdata[15:0];
         wl_ff    <= req_tdata[31:16];
         wr_ff    <= req_tdata[47:32];
         mix_l_ff <= req_tdata[63:48];
         mix_r_ff <= req_tdata[79:64];
      end
   end

   // Sample store write, scaled to the stored precision.
   logic signed [31:0]      wl_wide;
   logic signed [31:0]      wr_wide;
   logic [SAMPLE_BITS-1:0]  wl_store;
   logic [SAMPLE_BITS-1:0]  wr_store;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    addr_ok;

   always_comb begin
      wl_wide  = (32'(wl_ff) <<< UP_SH) >>> DN_SH;
      wr_wide  = (32'(wr_ff) <<< UP_SH) >>> DN_SH;
      wl_store = wl_wide[SAMPLE_BITS-1:0];
      wr_store = wr_wide[SAMPLE_BITS-1:0];
      wr_addr  = ADDR_W'(addr_ff);
      addr_ok  = (32'(addr_ff) < 32'(MAX_FRAMES));
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && addr_ok) begin
         sample_mem[wr_addr] <= {wr_store, wl_store};
      end
   end

   // Frame index, its clamped neighbour and the end-of-data test.
   logic [CMP_W-1:0]           idx_w;
   logic [CMP_W-1:0]           idx_inc;
   logic [CMP_W-1:0]           idx1_w;
   logic [CMP_W-1:0]           fc_w;
   logic                       eod;
   logic [ADDR_W-1:0]          rd_addr0;
   logic [ADDR_W-1:0]          rd_addr1;

   always_comb begin
      idx_w   = CMP_W'(phase_ff[31:PHASE_FRAC_BITS]);
      fc_w    = (CMP_W'(frame_count_ff) > CMP_W'(MAX_FRAMES)) ?
                CMP_W'(MAX_FRAMES) : CMP_W'(frame_count_ff);
      eod     = (fc_w == '0) || (idx_w >= fc_w);
      idx_inc = idx_w + CMP_W'(1);
      idx1_w  = (idx_inc == fc_w) ? idx_w : idx_inc;
      rd_addr0 = idx_w[ADDR_W-1:0];
      rd_addr1 = idx1_w[ADDR_W-1:0];
   end

   // Both neighbouring frames are read together.
   always_ff @(posedge clock) begin
      if (cmd.tick_eval) begin
         rd0_ff <= sample_mem[rd_addr0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_eval) begin
         rd1_ff <= sample_mem[rd_addr1];
      end
   end

   // Envelope and per-tick voice updates.
   logic [16:0] fil_sum;
   logic [15:0] fil_next;
   logic [15:0] env_in;
   logic [15:0] fo_step;
   logic [15:0] fol_next;
   logic [31:0] env_prod;
   logic [15:0] env_d;
   logic [32:0] phase_sum;
   logic [31:0] phase_next;
   logic [31:0] elapsed_next;
   logic        fading_next;
   logic        done;

   always_comb begin
      fil_sum  = {1'b0, fil_ff} + {1'b0, clamp_step(fade_in_step_ff)};
      fil_next = (fil_sum > {1'b0, LEVEL_UNITY}) ? LEVEL_UNITY : fil_sum[15:0];
      env_in   = (fil_ff > LEVEL_UNITY) ? LEVEL_UNITY : fil_ff;
      fo_step  = clamp_step(fade_out_step_ff);
      env_prod = env_in * fol_ff;
      env_d    = fading_ff ? env_prod[30:15] : env_in;
      fol_next = fol_ff;
      if (fading_ff) begin
         fol_next = (fol_ff > fo_step) ? fol_ff - fo_step : 16'd0;
      end
      phase_sum    = {1'b0, phase_ff} + 33'(phase_step_ff);
      phase_next   = phase_sum[32] ? 32'hFFFF_FFFF : phase_sum[31:0];
      elapsed_next = (elapsed_ff == 32'hFFFF_FFFF) ? elapsed_ff : elapsed_ff + 32'd1;
      fading_next  = fading_ff || ((max_play_ff != 32'd0) && (elapsed_next >= max_play_ff));
      done         = fading_next && (fol_next == 16'd0);
   end

   always_comb begin
      phase_in   = phase_ff;
      fil_in     = fil_ff;
      fol_in     = fol_ff;
      fading_in  = fading_ff;
      playing_in = playing_ff;
      elapsed_in = elapsed_ff;
      if (cmd.voice_start) begin
         phase_in   = 32'd0;
         fil_in     = 16'd0;
         fol_in     = LEVEL_UNITY;
         fading_in  = 1'b0;
         playing_in = 1'b1;
         elapsed_in = 32'd0;
      end else if (cmd.voice_stop && playing_ff) begin
         fading_in = 1'b1;
         fol_in    = LEVEL_UNITY;
      end else if (cmd.tick_eval && playing_ff) begin
         if (eod) begin
            playing_in = 1'b0;
         end else begin
            phase_in   = phase_next;
            fil_in     = fil_next;
            fol_in     = fol_next;
            fading_in  = fading_next;
            elapsed_in = elapsed_next;
            playing_in = !done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 32'd0;
         fil_ff     <= 16'd0;
         fol_ff     <= LEVEL_UNITY;
         fading_ff  <= 1'b0;
         playing_ff <= 1'b0;
         elapsed_ff <= 32'd0;
      end else begin
         phase_ff   <= phase_in;
         fil_ff     <= fil_in;
         fol_ff     <= fol_in;
         fading_ff  <= fading_in;
         playing_ff <= playing_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Tick decode results that travel with the frame.
   always_ff @(posedge clock) begin
      if (cmd.tick_eval) begin
         frac_ff   <= phase_ff[PHASE_FRAC_BITS-1:0];
         env_ff    <= env_d;
         zero_ff   <= !playing_ff || eod;
         active_ff <= playing_ff && !eod && !done;
         fin_ff    <= playing_ff && (eod || done);
      end
   end

   // Interpolation products and the combined gain.
   logic signed [SAMPLE_BITS-1:0] s0_l, s1_l, s0_r, s1_r;
   logic signed [DIFF_W-1:0]      diff_l, diff_r;

   always_comb begin
      s0_l   = rd0_ff[SAMPLE_BITS-1:0];
      s1_l   = rd1_ff[SAMPLE_BITS-1:0];
      s0_r   = rd0_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
      s1_r   = rd1_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
      diff_l = DIFF_W'(s1_l) - DIFF_W'(s0_l);
      diff_r = DIFF_W'(s1_r) - DIFF_W'(s0_r);
   end

   always_ff @(posedge clock) begin
      if (cmd.interp_en) begin
         iprod_l_ff <= diff_l * $signed({1'b0, frac_ff});
         iprod_r_ff <= diff_r * $signed({1'b0, frac_ff});
         ge_ff      <= gain_ff * env_ff;
      end
   end

   // Interpolated sample scaled by gain and envelope.
   logic signed [IPW-1:0]         vsum_l, vsum_r;
   logic signed [SAMPLE_BITS-1:0] v_l, v_r, v_rs;

   always_comb begin
      vsum_l = IPW'(s0_l) + (iprod_l_ff >>> PHASE_FRAC_BITS);
      vsum_r = IPW'(s0_r) + (iprod_r_ff >>> PHASE_FRAC_BITS);
      v_l    = vsum_l[SAMPLE_BITS-1:0];
      v_r    = vsum_r[SAMPLE_BITS-1:0];
      v_rs   = stereo_ff ? v_r : v_l;
   end

   always_ff @(posedge clock) begin
      if (cmd.scale_en) begin
         vprod_l_ff <= v_l * $signed({1'b0, ge_ff});
         vprod_r_ff <= v_rs * $signed({1'b0, ge_ff});
      end
   end

   // Round, add onto the mix and saturate.
   logic signed [SPW-1:0]   t_l, t_r;
   logic signed [ACC_W-1:0] add_l, add_r;
   logic signed [ACC_W-1:0] sum_l, sum_r;

   always_comb begin
      t_l   = (vprod_l_ff + BIAS) >>> SH;
      t_r   = (vprod_r_ff + BIAS) >>> SH;
      add_l = zero_ff ? '0 : t_l[ACC_W-1:0];
      add_r = zero_ff ? '0 : t_r[ACC_W-1:0];
      sum_l = ACC_W'(mix_l_ff) + add_l;
      sum_r = ACC_W'(mix_r_ff) + add_r;
   end

   // Output register holds a result until its transaction completes.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata_ff <= {6'd0, fin_ff, active_ff, sat16(sum_r), sat16(sum_l)};
      end
   end

   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_tdata       = rsp_tdata_ff;
   assign status.op       = op_ff;
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

endmodule

// ===== rtl/sample_voice_resampling_player_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tuser: opcode; tdata: addr, samples, mix
// rsp_      out        rsp_tvalid/rsp_tready   tdata: out_left, out_right, active, finished
// csr_      in         csr_valid/csr_ready     csr_addr: register index; csr_wdata: value
//
// Write, start and stop items are accepted, then decoded and acted on.
// A tick steps through accept, state update with a dual-read of the sample
// memory, interpolation multiply, gain multiply, then round, mix and saturate.
// A tick stalls in its last step only while the previous result is unclaimed.
// Reset is synchronous and clears control state and configuration; the sample
// memory is not cleared and holds undefined data until written.

module sample_voice_resampling_player_top #(
   parameter int MAX_FRAMES      = svrp_pkg::DEF_MAX_FRAMES,
   parameter int SAMPLE_BITS     = svrp_pkg::DEF_SAMPLE_BITS,
   parameter int PHASE_FRAC_BITS = svrp_pkg::DEF_PHASE_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] opcode
   input  logic [svrp_pkg::REQ_USER_W-1:0]   req_tuser,
   // [15:0] sample_addr, [31:16] sample_left, [47:32] sample_right,
   // [63:48] mix_in_left, [79:64] mix_in_right
   input  logic [svrp_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] out_left, [31:16] out_right, [32] voice_active, [33] finished,
   // [39:34] zero
   output logic [svrp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [svrp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [svrp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import svrp_pkg::*;

   svrp_cmd_type    cmd;
   svrp_status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   // Operation sequencer.
   svrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Sample store, voice state and arithmetic.
   svrp_datapath #(
      .MAX_FRAMES      (MAX_FRAMES),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/svrp_checker.sv =====
`timescale 1ns / 1ps

module svrp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [svrp_pkg::REQ_USER_W-1:0]   req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [svrp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import svrp_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A finishing voice never reports itself as still active.
   a_fin_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> !rsp_tdata[32])
      else $error("finished and active on the same result");

   // Items are worked one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // A fresh result follows a tick transaction by the fixed pipeline depth.
   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && (req_tuser == OP_TICK), 5))
      else $error("result without a matching tick");

endmodule

bind sample_voice_resampling_player_top svrp_checker u_svrp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/sample_voice_resampling_player_top_tb.sv =====
`timescale 1ns / 1ps

module sample_voice_resampling_player_top_tb;
   import svrp_pkg::*;

   localparam int FRAMES = DEF_MAX_FRAMES;
   localparam int FRAC = DEF_PHASE_FRAC_BITS;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_ITEMS = 500;
   localparam longint PHASE_TOP = 64'h0000_0000_FFFF_FFFF;
   localparam longint ROUND_BIAS = 64'sd1 <<< 28;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [15:0] smp_l;
      logic [15:0] smp_r;
      logic [15:0] mix_l;
      logic [15:0] mix_r;
   } voice_req_type;

   typedef struct {
      logic [15:0] out_l;
      logic [15:0] out_r;
      logic        active;
      logic        finished;
   } voice_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Items waiting to be offered, and mix results still owed by the block.
   voice_req_type pending_req_q[$];
   voice_rsp_type mix_expect_q[$];
   voice_req_type req_held;

   // Predicted voice state and register copies, at their reset values.
   logic [15:0] mem_left [FRAMES];
   logic [15:0] mem_right [FRAMES];
   int unsigned v_phase = 0;
   int unsigned v_fade_in = 0;
   int unsigned v_fade_out = 32'(LEVEL_UNITY);
   logic v_fading = 1'b0;
   logic v_playing = 1'b0;
   int unsigned v_elapsed = 0;
   int unsigned cfg_step = 65536;
   int unsigned cfg_gain = 8211;
   int unsigned cfg_fade_in = 34;
   int unsigned cfg_fade_out = 14;
   int unsigned cfg_frames = 1;
   int unsigned cfg_max_play = 0;
   logic cfg_stereo = 1'b1;

   // Stimulus bookkeeping: which frames hold data, and where the phase may be.
   bit gen_filled [FRAMES];
   int unsigned gen_phase = 0;
   bit gen_live = 1'b0;
   int items_sent = 0;

   // Flow control between the stimulus and the two stream processes.
   bit calm = 1'b0;
   int hold_asked = 0;
   int hold_done = 0;
   int hold_left = 0;
   int stall_left = 0;
   int gap_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   sample_voice_resampling_player_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Fade steps outside one to unity are pulled into that range.
   function automatic int unsigned limit_step(input int unsigned s);
      if (s == 0) return 1;
      if (s > LEVEL_UNITY) return 32'(LEVEL_UNITY);
      return s;
   endfunction

   function automatic int unsigned eff_frames();
      return (cfg_frames > FRAMES) ? FRAMES : cfg_frames;
   endfunction

   function automatic logic [15:0] clip16(input longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // Linear step from one stored frame towards the next, floored.
   function automatic longint lerp(input logic [15:0] a, input logic [15:0] b,
                                   input int unsigned frac);
      longint s0, s1, fr;
      s0 = longint'($signed(a));
      s1 = longint'($signed(b));
      fr = longint'(frac);
      return s0 + (((s1 - s0) * fr) >>> FRAC);
   endfunction

   // Advances the predicted voice by one accepted transaction.
   task automatic voice_predict(input voice_req_type it);
      voice_rsp_type r;
      int unsigned fc, idx, idx1, frac, st;
      longint vl, vr, env, add_l, add_r, np;
      logic fin;
      add_l = 0;
      add_r = 0;
      fin = 1'b0;
      case (it.op)
         OP_WRITE: begin
            mem_left[it.addr] = it.smp_l;
            mem_right[it.addr] = it.smp_r;
         end
         OP_START: begin
            v_phase = 0;
            v_fade_in = 0;
            v_fade_out = 32'(LEVEL_UNITY);
            v_fading = 1'b0;
            v_playing = 1'b1;
            v_elapsed = 0;
         end
         OP_STOP: begin
            if (v_playing) begin
               v_fading = 1'b1;
               v_fade_out = 32'(LEVEL_UNITY);
            end
         end
         default: begin
            if (v_playing) begin
               fc = eff_frames();
               idx = v_phase >> FRAC;
               if (fc == 0 || idx >= fc) begin
                  // Out of data: the voice stops with no contribution.
                  v_playing = 1'b0;
                  fin = 1'b1;
               end else begin
                  idx1 = (idx + 1 < fc) ? idx + 1 : fc - 1;
                  frac = v_phase & ((1 << FRAC) - 1);
                  vl = lerp(mem_left[16'(idx)], mem_left[16'(idx1)], frac);
                  vr = cfg_stereo ? lerp(mem_right[16'(idx)], mem_right[16'(idx1)], frac)
                                  : vl;

                  env = longint'((v_fade_in > LEVEL_UNITY) ? 32'(LEVEL_UNITY) : v_fade_in);
                  v_fade_in = v_fade_in + limit_step(cfg_fade_in);
                  if (v_fade_in > LEVEL_UNITY) v_fade_in = 32'(LEVEL_UNITY);

                  if (v_fading) begin
                     st = limit_step(cfg_fade_out);
                     env = (env * longint'(v_fade_out)) >>> 15;
                     v_fade_out = (v_fade_out > st) ? v_fade_out - st : 0;
                  end

                  add_l = (vl * longint'(cfg_gain) * env + ROUND_BIAS) >>> 29;
                  add_r = (vr * longint'(cfg_gain) * env + ROUND_BIAS) >>> 29;

                  np = longint'(v_phase) + longint'(cfg_step);
                  v_phase = (np > PHASE_TOP) ? 32'hFFFF_FFFF : np[31:0];

                  if (v_elapsed != 32'hFFFF_FFFF) v_elapsed++;
                  if (cfg_max_play != 0 && v_elapsed >= cfg_max_play) v_fading = 1'b1;

                  if (v_fading && v_fade_out == 0) begin
                     v_playing = 1'b0;
                     fin = 1'b1;
                  end
               end
            end
            r.out_l = clip16(longint'($signed(it.mix_l)) + add_l);
            r.out_r = clip16(longint'($signed(it.mix_r)) + add_r);
            r.active = v_playing;
            r.finished = fin;
            mix_expect_q.push_back(r);
         end
      endcase
   endtask

   task automatic apply_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      case (idx)
         CSR_PHASE_STEP:    cfg_step = 32'(value[23:0]);
         CSR_GAIN:          cfg_gain = 32'(value[15:0]);
         CSR_FADE_IN_STEP:  cfg_fade_in = 32'(value[15:0]);
         CSR_FADE_OUT_STEP: cfg_fade_out = 32'(value[15:0]);
         CSR_FRAME_COUNT:   cfg_frames = 32'(value[16:0]);
         CSR_MAX_PLAY:      cfg_max_play = value;
         CSR_STEREO:        cfg_stereo = value[0];
         default: ;
      endcase
   endtask

   // One register write; called just after a rising edge, returns just after one.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      csr_addr <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sample or mix value that lands on the extremes now and then.
   function automatic logic [15:0] rnd16();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                            input logic [15:0] sl, input logic [15:0] sr,
                            input logic [15:0] ml, input logic [15:0] mr);
      voice_req_type it;
      it.op = op;
      it.addr = addr;
      it.smp_l = sl;
      it.smp_r = sr;
      it.mix_l = ml;
      it.mix_r = mr;
      pending_req_q.push_back(it);
      items_sent++;
   endtask

   task automatic queue_write(input logic [15:0] addr, input logic [15:0] l,
                              input logic [15:0] r);
      send_item(OP_WRITE, addr, l, r, rnd16(), rnd16());
      gen_filled[addr] = 1'b1;
   endtask

   task automatic queue_start();
      send_item(OP_START, 16'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
      gen_live = 1'b1;
      gen_phase = 0;
   endtask

   task automatic queue_stop();
      send_item(OP_STOP, 16'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
   endtask

   // A tick; any frame it may read is written first so no empty entry is read.
   task automatic queue_tick(input logic [15:0] ml, input logic [15:0] mr);
      int unsigned fc, idx, idx1;
      longint np;
      fc = eff_frames();
      idx = gen_phase >> FRAC;
      if (gen_live) begin
         if (fc == 0 || idx >= fc) begin
            gen_live = 1'b0;
         end else begin
            idx1 = (idx + 1 < fc) ? idx + 1 : fc - 1;
            if (!gen_filled[16'(idx)]) queue_write(16'(idx), rnd16(), rnd16());
            if (!gen_filled[16'(idx1)]) queue_write(16'(idx1), rnd16(), rnd16());
            np = longint'(gen_phase) + longint'(cfg_step);
            gen_phase = (np > PHASE_TOP) ? 32'hFFFF_FFFF : np[31:0];
         end
      end
      send_item(OP_TICK, 16'($urandom), rnd16(), rnd16(), ml, mr);
   endtask

   // Waits until every transaction has gone through and the block is quiet.
   task automatic wait_idle();
      while (pending_req_q.size() != 0 || req_tvalid || mix_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A fresh setting of every register, extremes included.
   task automatic random_config();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 32'hFF_FFFF;
         2: v = 32'h1_0000;
         3: v = $urandom_range(0, 32'hFF_FFFF);
         default: v = $urandom_range(32'h2000, 32'h1_8000);
      endcase
      csr_write(CSR_PHASE_STEP, v);
      case ($urandom_range(0, 5))
         0: v = 0;
         1: v = 65535;
         default: v = $urandom_range(0, 65535);
      endcase
      csr_write(CSR_GAIN, v);
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 1;
         2: v = 32'(LEVEL_UNITY);
         3: v = 65535;
         default: v = $urandom_range(300, 12000);
      endcase
      csr_write(CSR_FADE_IN_STEP, v);
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 1;
         2: v = 32'(LEVEL_UNITY);
         3: v = 65535;
         default: v = $urandom_range(300, 12000);
      endcase
      csr_write(CSR_FADE_OUT_STEP, v);
      case ($urandom_range(0, 15))
         0: v = 0;
         1: v = 1;
         2: v = 65536;
         3: v = 131071;
         4: v = $urandom_range(2, 131071);
         default: v = $urandom_range(2, 24);
      endcase
      csr_write(CSR_FRAME_COUNT, v);
      case ($urandom_range(0, 9))
         6: v = 32'hFFFF_FFFF;
         7: v = 1;
         8, 9: v = $urandom_range(4, 40);
         default: v = 0;
      endcase
      csr_write(CSR_MAX_PLAY, v);
      csr_write(CSR_STEREO, $urandom_range(0, 1));
   endtask

   // Mostly start-and-play sequences, with stray items around them.
   task automatic random_phase();
      int unsigned fc, sel;
      fc = eff_frames();
      repeat ($urandom_range(1, 3)) begin
         repeat ($urandom_range(0, 2)) begin
            sel = $urandom_range(0, 2);
            if (sel == 0) queue_stop();
            else if (sel == 1) queue_write(16'($urandom), rnd16(), rnd16());
            else queue_tick(rnd16(), rnd16());
         end
         queue_start();
         repeat ($urandom_range(6, 36)) begin
            sel = $urandom_range(0, 29);
            if (sel == 0) queue_stop();
            else if (sel == 1 && fc > 0)
               queue_write(16'($urandom_range(0, fc - 1)), rnd16(), rnd16());
            else if (sel == 2) queue_start();
            else queue_tick(rnd16(), rnd16());
         end
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Request driver: offers queued items, predicting each accepted transaction.
   always @(posedge clock) begin : req_driver
      voice_req_type nxt;
      logic accepted;
      accepted = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (accepted) begin
            voice_predict(req_held);
            gap_left = pick_gap();
         end
         if (accepted || !req_tvalid) begin
            if (gap_left == 0 && pending_req_q.size() > 0) begin
               nxt = pending_req_q.pop_front();
               req_held = nxt;
               req_tuser <= nxt.op;
               req_tdata <= {nxt.mix_r, nxt.mix_l, nxt.smp_r, nxt.smp_l, nxt.addr};
               req_tvalid <= 1'b1;
            end else begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result sink: random stalls, and on request one long hold-off.
   always @(posedge clock) begin : rsp_sink
      logic rdy;
      rdy = 1'b1;
      if (reset) begin
         rdy = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (hold_done != hold_asked && rsp_tvalid) begin
         hold_left = LONG_HOLD;
         hold_done++;
         rdy = 1'b0;
      end else if (!calm) begin
         if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if ($urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rdy = 1'b0;
         end
      end
      rsp_tready <= rdy;
   end

   // Result monitor: each transaction is checked against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      voice_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mix_expect_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, '0);
         end else begin
            want = mix_expect_q.pop_front();
            if (rsp_tdata[15:0] !== want.out_l)
               report_mismatch("out_left", 40'(rsp_tdata[15:0]), 40'(want.out_l));
            if (rsp_tdata[31:16] !== want.out_r)
               report_mismatch("out_right", 40'(rsp_tdata[31:16]), 40'(want.out_r));
            if (rsp_tdata[32] !== want.active)
               report_mismatch("voice_active", 40'(rsp_tdata[32]), 40'(want.active));
            if (rsp_tdata[33] !== want.finished)
               report_mismatch("finished", 40'(rsp_tdata[33]), 40'(want.finished));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int base;
      int phase_no;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: idle tick, stop while idle, one frame played to its end.
      queue_tick(16'h7FFF, 16'h8000);
      queue_stop();
      queue_write(16'h0000, 16'h7FFF, 16'h8000);
      queue_write(16'hFFFF, 16'h8000, 16'h7FFF);
      queue_start();
      queue_tick(16'h8000, 16'h7FFF);
      queue_tick(16'h0000, 16'hFFFF);
      queue_tick(16'h7FFF, 16'h7FFF);
      wait_idle();

      // Mono at half speed, full gain; stop while playing and again mid-fade.
      csr_write(CSR_PHASE_STEP, 32'h8000);
      csr_write(CSR_GAIN, 32'd65535);
      csr_write(CSR_FADE_IN_STEP, 32'd65535);
      csr_write(CSR_FADE_OUT_STEP, 32'd0);
      csr_write(CSR_FRAME_COUNT, 32'd2);
      csr_write(CSR_MAX_PLAY, 32'd0);
      csr_write(CSR_STEREO, 32'd0);
      queue_write(16'd1, 16'h8000, 16'h7FFF);
      queue_start();
      queue_tick(16'h7FFF, 16'h7FFF);
      queue_tick(16'h7FFF, 16'h7FFF);
      queue_stop();
      queue_tick(16'h8000, 16'h8000);
      queue_stop();
      queue_tick(16'h8000, 16'h8000);
      queue_tick(16'h1234, 16'hEDCB);
      wait_idle();

      // No frames at all, then an oversized count with the play limit and a fast fade.
      csr_write(CSR_FRAME_COUNT, 32'd0);
      queue_start();
      queue_tick(16'h0100, 16'hFF00);
      wait_idle();
      csr_write(CSR_PHASE_STEP, 32'hFF_FFFF);
      csr_write(CSR_GAIN, 32'd16384);
      csr_write(CSR_FADE_IN_STEP, 32'd0);
      csr_write(CSR_FADE_OUT_STEP, 32'(LEVEL_UNITY));
      csr_write(CSR_FRAME_COUNT, 32'd131071);
      csr_write(CSR_MAX_PLAY, 32'd3);
      csr_write(CSR_STEREO, 32'd1);
      queue_start();
      repeat (5) queue_tick(rnd16(), rnd16());
      wait_idle();

      // Random settings and sequences; one phase holds off the results for long.
      base = items_sent;
      phase_no = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         wait_idle();
         random_config();
         calm = (phase_no % 4 == 2);
         if (phase_no == 1) hold_asked++;
         random_phase();
         phase_no++;
      end
      wait_idle();

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
